// File: rtl/sfnc_pkg.sv
// ---------------------------------------------------------------------------
// sfnc_pkg
// shared types, widths and the color averaging function of the facet block
// ---------------------------------------------------------------------------
`default_nettype none

package sfnc_pkg;

    localparam int COORD_BITS           = 24;
    localparam int NORMAL_FRACTION_BITS = 30;

    // edge, cross product and square widths
    localparam int EW   = COORD_BITS + 1;
    localparam int PW   = 2 * EW;
    localparam int CW   = PW + 1;
    localparam int MW   = CW;
    localparam int LOW  = (MW + 1) / 2;
    localparam int HIW  = MW - LOW;
    localparam int SQW  = 2 * MW;
    localparam int SW   = SQW + 2;
    localparam int WW   = SW + 2 * NORMAL_FRACTION_BITS + 3;
    localparam int QW   = NORMAL_FRACTION_BITS + 1;
    localparam int BW   = $clog2(QW);
    localparam int OW   = 32;

    localparam int          COLOR_SHIFT = 27;
    localparam logic [16:0] COLOR_RECIP = 17'd87725;
    localparam logic [4:0]  CHAN_FULL   = 5'd31;
    localparam logic [15:0] VALID_BIT   = 16'h8000;

    localparam logic [7:0] REG_COLOR_MODE     = 8'd0;
    localparam logic [7:0] REG_COLORS_PRESENT = 8'd1;

    typedef struct packed {
        logic [2:0][EW-1:0] e1;
        logic [2:0][EW-1:0] e2;
        logic [15:0]        color_word;
    } t_tri;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CROSS,
        BK_SQUARE,
        BK_CHECK,
        BK_NINIT,
        BK_TRIAL,
        BK_CMP,
        BK_DONE
    } t_back_state;

    // round(sum * 31 / 765) clamped, by reciprocal multiply
    function automatic logic [4:0] avg_channel(input logic [9:0] sum);
        logic [15:0] x;
        logic [32:0] p;
        logic [5:0]  v;
        x = 16'({6'd0, sum} * 16'd62) + 16'd765;
        p = {17'd0, x} * {16'd0, COLOR_RECIP};
        v = p[COLOR_SHIFT+5:COLOR_SHIFT];
        return (v > 6'(CHAN_FULL)) ? CHAN_FULL : v[4:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/sfnc_fifo.sv
// ---------------------------------------------------------------------------
// sfnc_fifo
// two-entry queue of triangle jobs between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module sfnc_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  wire sfnc_pkg::t_tri i_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output logic               o_empty,
    output sfnc_pkg::t_tri     o_data
);
    import sfnc_pkg::*;

    t_tri       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfnc_front.sv
// ---------------------------------------------------------------------------
// sfnc_front
// collects corners, sums colors, forms edges and the color word
// ---------------------------------------------------------------------------
`default_nettype none

module sfnc_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_x,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_y,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_z,
    input  wire logic [7:0]                i_red,
    input  wire logic [7:0]                i_green,
    input  wire logic [7:0]                i_blue,
    input  wire logic                      i_color_mode,
    input  wire logic                      i_colors_present,
    output logic                           o_job_wr,
    output sfnc_pkg::t_tri                 o_job
);
    import sfnc_pkg::*;

    logic [1:0]            r_count;
    logic [9:0]            r_sum [3];
    logic [COORD_BITS-1:0] r_held [6];

    logic [9:0]            n_sum [3];
    logic [COORD_BITS-1:0] in_c [3];
    logic [7:0]            in_col [3];
    logic [4:0]            chan [3];
    logic                  third;

    assign in_c[0]   = i_coord_x;
    assign in_c[1]   = i_coord_y;
    assign in_c[2]   = i_coord_z;
    assign in_col[0] = i_red;
    assign in_col[1] = i_green;
    assign in_col[2] = i_blue;
    assign third     = (r_count == 2'd2);
    assign o_job_wr  = i_accept && third;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = r_sum[i] + {2'd0, in_col[i]};
            chan[i]  = i_colors_present ? avg_channel(n_sum[i]) : CHAN_FULL;
            o_job.e1[i] = EW'($signed(r_held[3+i])) - EW'($signed(r_held[i]));
            o_job.e2[i] = EW'($signed(in_c[i])) - EW'($signed(r_held[i]));
        end
        if (i_color_mode) begin
            o_job.color_word = {1'b0, chan[2], chan[1], chan[0]};
        end else begin
            o_job.color_word = VALID_BIT | {1'b0, chan[0], chan[1], chan[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= 10'd0;
            end
        end else if (i_accept) begin
            r_count <= third ? 2'd0 : r_count + 2'd1;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= third ? 10'd0 : n_sum[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !third) begin
            for (int i = 0; i < 3; i++) begin
                if (r_count[0]) begin
                    r_held[3+i] <= in_c[i];
                end else begin
                    r_held[i] <= in_c[i];
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfnc_back.sv
// ---------------------------------------------------------------------------
// sfnc_back
// cross product, squared length and bit-serial normalization per triangle
// ---------------------------------------------------------------------------
`default_nettype none

module sfnc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_empty,
    input  wire sfnc_pkg::t_tri i_job,
    output logic                o_job_rd,
    input  wire logic           i_pop,
    output logic                o_empty,
    output logic [31:0]         o_normal_x,
    output logic [31:0]         o_normal_y,
    output logic [31:0]         o_normal_z,
    output logic                o_degenerate,
    output logic [15:0]         o_color_word
);
    import sfnc_pkg::*;

    t_back_state r_state, n_state;

    logic [2:0]            r_k;
    logic [1:0]            r_j;
    logic [2:0][EW-1:0]    r_e1;
    logic [2:0][EW-1:0]    r_e2;
    logic [15:0]           r_color;
    logic signed [CW-1:0]  r_cross [3];
    logic [SQW-1:0]        r_sq [3];
    logic [SW-1:0]         r_s;
    logic [WW-1:0]         r_a, r_d, r_s2, r_t, r_rhs;
    logic [BW-1:0]         r_b;
    logic [QW-1:0]         r_q;
    logic [OW-1:0]         r_norm [3];
    logic                  r_degen;
    logic                  r_out_valid;
    logic [OW-1:0]         r_out_n [3];
    logic                  r_out_degen;
    logic [15:0]           r_out_color;

    logic                  out_load;
    logic                  cross_last, square_last, bit_last;
    logic [EW-1:0]         ma, mb;
    logic signed [PW-1:0]  prod;
    logic                  prod_sub;
    logic [MW-1:0]         mag;
    logic [LOW-1:0]        pa, pb;
    logic [2*LOW-1:0]      part;
    logic [SQW-1:0]        part_sh;
    logic                  le;
    logic [WW-1:0]         d_new;
    logic [OW-1:0]         q_ext;

    assign cross_last  = (r_k == 3'd5);
    assign square_last = (r_k == 3'd2) && (r_j == 2'd2);
    assign bit_last    = (r_b == '0);

    // cross product operand selection
    always_comb begin
        case (r_k)
            3'd0: begin ma = r_e1[1]; mb = r_e2[2]; prod_sub = 1'b0; end
            3'd1: begin ma = r_e1[2]; mb = r_e2[1]; prod_sub = 1'b1; end
            3'd2: begin ma = r_e1[2]; mb = r_e2[0]; prod_sub = 1'b0; end
            3'd3: begin ma = r_e1[0]; mb = r_e2[2]; prod_sub = 1'b1; end
            3'd4: begin ma = r_e1[0]; mb = r_e2[1]; prod_sub = 1'b0; end
            default: begin ma = r_e1[1]; mb = r_e2[0]; prod_sub = 1'b1; end
        endcase
        prod = $signed(ma) * $signed(mb);
    end

    // square of one cross component from three partial products
    always_comb begin
        mag = r_cross[r_j][CW-1] ? MW'(-r_cross[r_j]) : MW'(r_cross[r_j]);
        case (r_k)
            3'd0:    begin pa = mag[LOW-1:0];           pb = mag[LOW-1:0]; end
            3'd1:    begin pa = LOW'(mag[MW-1:LOW]);    pb = mag[LOW-1:0]; end
            default: begin pa = LOW'(mag[MW-1:LOW]);    pb = LOW'(mag[MW-1:LOW]); end
        endcase
        part = pa * pb;
        case (r_k)
            3'd0:    part_sh = SQW'(part);
            3'd1:    part_sh = SQW'(part) << (LOW + 1);
            default: part_sh = SQW'(part) << (2 * LOW);
        endcase
    end

    assign le    = (r_t <= r_rhs);
    assign d_new = le ? r_d + (r_s2 << 1) : r_d;
    assign q_ext = r_cross[r_j][CW-1] ? -OW'(r_q) : OW'(r_q);

    // outputs of the sequencer
    always_comb begin
        o_job_rd = (r_state == BK_IDLE) && !i_job_empty;
        out_load = (r_state == BK_DONE) && (!r_out_valid || i_pop);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:   if (!i_job_empty) n_state = BK_CROSS;
            BK_CROSS:  if (cross_last) n_state = BK_SQUARE;
            BK_SQUARE: if (square_last) n_state = BK_CHECK;
            BK_CHECK:  n_state = (r_s == '0) ? BK_DONE : BK_NINIT;
            BK_NINIT:  n_state = BK_TRIAL;
            BK_TRIAL:  n_state = BK_CMP;
            BK_CMP: begin
                if (!bit_last) begin
                    n_state = BK_TRIAL;
                end else begin
                    n_state = (r_j == 2'd2) ? BK_DONE : BK_NINIT;
                end
            end
            BK_DONE:   if (out_load) n_state = BK_IDLE;
            default:   n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_e1    <= i_job.e1;
                r_e2    <= i_job.e2;
                r_color <= i_job.color_word;
                r_k     <= 3'd0;
                r_s     <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_cross[i] <= '0;
                    r_sq[i]    <= '0;
                    r_norm[i]  <= '0;
                end
            end
            BK_CROSS: begin
                if (prod_sub) begin
                    r_cross[r_k[2:1]] <= r_cross[r_k[2:1]] - CW'(prod);
                end else begin
                    r_cross[r_k[2:1]] <= r_cross[r_k[2:1]] + CW'(prod);
                end
                r_k <= cross_last ? 3'd0 : r_k + 3'd1;
                r_j <= 2'd0;
            end
            BK_SQUARE: begin
                r_sq[r_j] <= r_sq[r_j] + part_sh;
                r_s       <= r_s + SW'(part_sh);
                if (r_k == 3'd2) begin
                    r_k <= 3'd0;
                    r_j <= r_j + 2'd1;
                end else begin
                    r_k <= r_k + 3'd1;
                end
            end
            BK_CHECK: begin
                r_j     <= 2'd0;
                r_degen <= (r_s == '0);
            end
            BK_NINIT: begin
                r_a   <= '0;
                r_d   <= '0;
                r_s2  <= WW'(r_s) << (2 * NORMAL_FRACTION_BITS);
                r_rhs <= WW'(r_sq[r_j]) << (2 * NORMAL_FRACTION_BITS);
                r_b   <= BW'(NORMAL_FRACTION_BITS);
                r_q   <= '0;
            end
            BK_TRIAL: begin
                r_t <= r_a + r_d + r_s2;
            end
            BK_CMP: begin
                if (le) begin
                    r_a      <= r_t;
                    r_q[r_b] <= 1'b1;
                end
                r_d  <= d_new >> 1;
                r_s2 <= r_s2 >> 2;
                if (bit_last) begin
                    r_j <= r_j + 2'd1;
                    r_norm[r_j] <= le ? (r_cross[r_j][CW-1] ? -OW'(r_q | QW'(1))
                                                             : OW'(r_q | QW'(1)))
                                      : q_ext;
                end else begin
                    r_b <= r_b - BW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            for (int i = 0; i < 3; i++) begin
                r_out_n[i] <= r_norm[i];
            end
            r_out_degen <= r_degen;
            r_out_color <= r_color;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_normal_x   = r_out_n[0];
    assign o_normal_y   = r_out_n[1];
    assign o_normal_z   = r_out_n[2];
    assign o_degenerate = r_out_degen;
    assign o_color_word = r_out_color;

endmodule

`default_nettype wire

// File: rtl/stl_facet_normal_and_color.sv
// ---------------------------------------------------------------------------
// stl_facet_normal_and_color
// facet unit normal and 5-5-5 color, one record per three corners
// ---------------------------------------------------------------------------
// Corners go in one per transfer and are taken in every cycle while the job
// queue has room; every third corner closes a triangle and queues one job.
// The back end takes one job at a time: cross products, then squaring, then
// per normal component a 31-bit restoring search with an add step and a
// compare step per bit; a degenerate triangle skips the search. That
// bit-serial search sets the rate. Results wait in an output register
// until popped; configuration is sampled as the third corner of a
// triangle is taken.
`default_nettype none

module stl_facet_normal_and_color (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // corner input queue side
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_x,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_y,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0] i_coord_z,
    input  wire logic [7:0]                    i_red,
    input  wire logic [7:0]                    i_green,
    input  wire logic [7:0]                    i_blue,
    // result queue side
    output logic                               empty,
    input  wire logic                          pop,
    output logic [31:0]                        o_normal_x,
    output logic [31:0]                        o_normal_y,
    output logic [31:0]                        o_normal_z,
    output logic                               o_degenerate,
    output logic [15:0]                        o_color_word,
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [7:0]                    i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import sfnc_pkg::*;

    logic r_color_mode;
    logic r_colors_present;

    logic accept;
    logic job_wr;
    logic job_rd;
    logic job_empty;
    t_tri job_in;
    t_tri job_out;

    // config always ready, only the low data bit matters
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode     <= 1'b0;
            r_colors_present <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_COLOR_MODE:     r_color_mode     <= i_cfg_data[0];
                REG_COLORS_PRESENT: r_colors_present <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // a corner transfer happens whenever push is high and the job queue has room
    assign accept = push && !full;

    sfnc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_color_mode     (r_color_mode),
        .i_colors_present (r_colors_present),
        .o_job_wr         (job_wr),
        .o_job            (job_in)
    );

    // decouples corner intake from the long normalization
    sfnc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_wr),
        .i_data  (job_in),
        .o_full  (full),
        .i_rd    (job_rd),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    sfnc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_empty  (job_empty),
        .i_job        (job_out),
        .o_job_rd     (job_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_degenerate (o_degenerate),
        .o_color_word (o_color_word)
    );

endmodule

`default_nettype wire

// File: dv/facet_watch.sv
// ---------------------------------------------------------------------------
// facet_watch
// predicts facet normal and color records from observed transfers and
// compares them with the records leaving the block
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module facet_watch (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire logic                             i_full,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0]  i_coord_x,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0]  i_coord_y,
    input  wire logic [sfnc_pkg::COORD_BITS-1:0]  i_coord_z,
    input  wire logic [7:0]                       i_red,
    input  wire logic [7:0]                       i_green,
    input  wire logic [7:0]                       i_blue,
    input  wire logic                             i_empty,
    input  wire logic                             i_pop,
    input  wire logic [31:0]                      i_normal_x,
    input  wire logic [31:0]                      i_normal_y,
    input  wire logic [31:0]                      i_normal_z,
    input  wire logic                             i_degenerate,
    input  wire logic [15:0]                      i_color_word,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             i_cfg_ready,
    input  wire logic [7:0]                       i_cfg_index,
    input  wire logic [31:0]                      i_cfg_data,
    output int                                    o_fail_count,
    output int                                    o_pending
);

    typedef struct {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] nz;
        logic        degen;
        logic [15:0] word;
    } t_facet_rec;

    t_facet_rec  facet_queue[$];
    logic        mode_blue_high;
    logic        use_colors;
    longint      held_pos[6];
    int          sum_rgb[3];
    int          corners_held;

    function automatic logic [31:0] unit_part(longint c, logic [199:0] sq_len);
        logic [199:0] mag, rhs, trial;
        logic [31:0]  q, t;
        mag = (c < 0) ? -c : c;
        rhs = (mag * mag) << (2 * sfnc_pkg::NORMAL_FRACTION_BITS);
        q = '0;
        // restoring search for floor(|c| * 2^F / sqrt(s))
        for (int b = sfnc_pkg::NORMAL_FRACTION_BITS; b >= 0; b--) begin
            t = q | (32'd1 << b);
            trial = t;
            trial = trial * trial * sq_len;
            if (trial <= rhs) q = t;
        end
        return (c < 0) ? -q : q;
    endfunction

    function automatic logic [4:0] chan_avg(int sum);
        int v;
        v = (sum * 62 + 765) / 1530;
        return (v > 31) ? 5'd31 : v[4:0];
    endfunction

    function automatic t_facet_rec facet_of_corners(longint p3x, longint p3y, longint p3z);
        t_facet_rec   rec;
        longint       ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [199:0] mx, my, mz, s;
        logic [4:0]   r, g, b;
        ax = held_pos[3] - held_pos[0];
        ay = held_pos[4] - held_pos[1];
        az = held_pos[5] - held_pos[2];
        bx = p3x - held_pos[0];
        by = p3y - held_pos[1];
        bz = p3z - held_pos[2];
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        mx = (cx < 0) ? -cx : cx;
        my = (cy < 0) ? -cy : cy;
        mz = (cz < 0) ? -cz : cz;
        s = mx * mx + my * my + mz * mz;
        if (s == 0) begin
            rec.nx = '0; rec.ny = '0; rec.nz = '0; rec.degen = 1'b1;
        end else begin
            rec.nx = unit_part(cx, s);
            rec.ny = unit_part(cy, s);
            rec.nz = unit_part(cz, s);
            rec.degen = 1'b0;
        end
        if (use_colors) begin
            r = chan_avg(sum_rgb[0]); g = chan_avg(sum_rgb[1]); b = chan_avg(sum_rgb[2]);
        end else begin
            r = sfnc_pkg::CHAN_FULL; g = sfnc_pkg::CHAN_FULL; b = sfnc_pkg::CHAN_FULL;
        end
        if (mode_blue_high) rec.word = {1'b0, b, g, r};
        else                rec.word = sfnc_pkg::VALID_BIT | {1'b0, r, g, b};
        return rec;
    endfunction

    task automatic report(string what, logic [31:0] want, logic [31:0] got);
        $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
        o_fail_count++;
    endtask

    initial o_fail_count = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_facet_rec want;
        longint     px, py, pz;
        if (!i_rst_n) begin
            mode_blue_high <= 1'b0;
            use_colors     <= 1'b1;
            corners_held    = 0;
            sum_rgb         = '{0, 0, 0};
            facet_queue.delete();
        end else begin
            // record leaving the block
            if (i_pop && !i_empty) begin
                if (facet_queue.size() == 0) begin
                    report("unexpected record", 32'h0, 32'(i_color_word));
                end else begin
                    want = facet_queue.pop_front();
                    if (i_normal_x !== want.nx) report("normal_x", want.nx, i_normal_x);
                    if (i_normal_y !== want.ny) report("normal_y", want.ny, i_normal_y);
                    if (i_normal_z !== want.nz) report("normal_z", want.nz, i_normal_z);
                    if (i_degenerate !== want.degen)
                        report("degenerate", 32'(want.degen), 32'(i_degenerate));
                    if (i_color_word !== want.word)
                        report("color_word", 32'(want.word), 32'(i_color_word));
                end
            end
            // register write, unknown indexes dropped
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == sfnc_pkg::REG_COLOR_MODE) mode_blue_high <= i_cfg_data[0];
                else if (i_cfg_index == sfnc_pkg::REG_COLORS_PRESENT) use_colors <= i_cfg_data[0];
            end
            // corner transfer
            if (i_push && !i_full) begin
                px = longint'($signed(i_coord_x));
                py = longint'($signed(i_coord_y));
                pz = longint'($signed(i_coord_z));
                sum_rgb[0] = (sum_rgb[0] + i_red) & 'h3FF;
                sum_rgb[1] = (sum_rgb[1] + i_green) & 'h3FF;
                sum_rgb[2] = (sum_rgb[2] + i_blue) & 'h3FF;
                if (corners_held < 2) begin
                    held_pos[corners_held * 3]     = px;
                    held_pos[corners_held * 3 + 1] = py;
                    held_pos[corners_held * 3 + 2] = pz;
                    corners_held++;
                end else begin
                    facet_queue = {facet_queue, facet_of_corners(px, py, pz)};
                    sum_rgb      = '{0, 0, 0};
                    corners_held = 0;
                end
            end
        end
        o_pending = facet_queue.size();
    end

endmodule

// File: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// corner stimulus, register settings and verdict for the facet block
// ---------------------------------------------------------------------------
// Triangles go in as three corner transfers each: a directed set first
// (axis normals, extreme coordinates, repeated and collinear corners, color
// extremes), then random phases, with register writes between phases while
// the block is drained. Both sides stall in random bursts except in the last
// phase. facet_watch predicts and compares every record.
`timescale 1ns / 100ps

module tb;

    localparam int CW         = sfnc_pkg::COORD_BITS;
    localparam int PHASES     = 8;
    localparam int TRIS_PHASE = 81;
    localparam int SETTLE     = 300;   // covers one full back end pass
    localparam int STUCK_MAX  = 5000;

    logic          i_clk;
    logic          i_rst_n;
    logic          push;
    logic          full;
    logic [CW-1:0] coord_x, coord_y, coord_z;
    logic [7:0]    red, green, blue;
    logic          empty;
    logic          pop;
    logic [31:0]   normal_x, normal_y, normal_z;
    logic          degenerate;
    logic [15:0]   color_word;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [7:0]    cfg_index;
    logic [31:0]   cfg_data;
    int            fail_count;
    int            pending;
    logic          quiet;      // no idling on either side
    int            stuck_cycles;

    stl_facet_normal_and_color i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .empty        (empty),
        .pop          (pop),
        .o_normal_x   (normal_x),
        .o_normal_y   (normal_y),
        .o_normal_z   (normal_z),
        .o_degenerate (degenerate),
        .o_color_word (color_word),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    facet_watch i_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_coord_x    (coord_x),
        .i_coord_y    (coord_y),
        .i_coord_z    (coord_z),
        .i_red        (red),
        .i_green      (green),
        .i_blue       (blue),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_normal_x   (normal_x),
        .i_normal_y   (normal_y),
        .i_normal_z   (normal_z),
        .i_degenerate (degenerate),
        .i_color_word (color_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // one corner transfer, then maybe an idle burst
    task automatic put_corner(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z,
                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge i_clk);
        push    <= 1'b1;
        coord_x <= x; coord_y <= y; coord_z <= z;
        red     <= r; green   <= g; blue    <= b;
        do @(posedge i_clk); while (full);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
    endtask

    task automatic put_tri(longint p[9], logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic rand_color);
        for (int k = 0; k < 3; k++) begin
            if (rand_color)
                put_corner(p[3*k][CW-1:0], p[3*k+1][CW-1:0], p[3*k+2][CW-1:0],
                           8'($urandom), 8'($urandom), 8'($urandom));
            else
                put_corner(p[3*k][CW-1:0], p[3*k+1][CW-1:0], p[3*k+2][CW-1:0], r, g, b);
        end
    endtask

    task automatic write_reg(logic [7:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // wait for every record, then for the back end to go quiet
    task automatic drain;
        @(negedge i_clk);
        push <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function automatic longint pick_coord(int kind);
        longint lo, hi;
        lo = -(longint'(1) << (CW - 1));
        hi = (longint'(1) << (CW - 1)) - 1;
        case (kind)
            0:       return longint'($signed($urandom_range(0, 2000))) - 1000;
            1: begin
                case ($urandom_range(0, 3))
                    0: return lo;
                    1: return hi;
                    2: return 0;
                    default: return -1;
                endcase
            end
            default: return longint'($signed(24'($urandom)));
        endcase
    endfunction

    task automatic random_tri;
        longint p[9];
        int     kind, sel;
        sel  = $urandom_range(0, 9);
        kind = (sel < 6) ? 2 : (sel < 8) ? 0 : 1;
        for (int k = 0; k < 9; k++) p[k] = pick_coord(kind);
        if (sel == 9) begin
            // repeated or collinear corners, small so the third stays in range
            for (int k = 0; k < 6; k++) p[k] = pick_coord(0);
            for (int k = 0; k < 3; k++)
                p[6+k] = ($urandom_range(0, 1) != 0) ? p[k] : 2 * p[3+k] - p[k];
        end
        if ($urandom_range(0, 7) == 0)
            put_tri(p, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00,
                    $urandom_range(0, 1) ? 8'hFF : 8'h00, 1'b0);
        else
            put_tri(p, 8'h0, 8'h0, 8'h0, 1'b1);
    endtask

    // result side: pop held high, with random stall bursts
    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 5) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // stall watchdog: cycles with no transfer of any kind
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_MAX) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        longint lo, hi;
        lo = -(longint'(1) << (CW - 1));
        hi = (longint'(1) << (CW - 1)) - 1;
        i_rst_n   = 1'b0;
        push      = 1'b0;
        coord_x   = '0; coord_y = '0; coord_z = '0;
        red       = '0; green   = '0; blue    = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        stuck_cycles = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed triangles under reset settings
        put_tri('{0, 0, 0, 256, 0, 0, 0, 256, 0}, 8'h00, 8'h00, 8'h00, 1'b0);
        put_tri('{0, 0, 0, 0, 256, 0, 256, 0, 0}, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // all corners in one spot
        put_tri('{5, -7, 9, 5, -7, 9, 5, -7, 9}, 8'hFF, 8'h00, 8'h80, 1'b0);
        // collinear corners
        put_tri('{-100, 20, 3, 0, 40, 6, 100, 60, 9}, 8'h01, 8'hFE, 8'h7F, 1'b0);
        put_tri('{lo, lo, lo, hi, hi, lo, lo, hi, hi}, 8'h00, 8'hFF, 8'h00, 1'b0);
        put_tri('{hi, 0, 0, 0, hi, 0, 0, 0, hi}, 8'h55, 8'hAA, 8'h33, 1'b0);
        put_tri('{lo, lo, lo, hi, lo, lo, lo, lo, hi}, 8'h00, 8'h00, 8'hFF, 1'b0);
        put_tri('{hi, hi, hi, lo, -1, 0, 0, lo, -1}, 8'h00, 8'h00, 8'h00, 1'b1);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            // settings walk through all four corners, plus an ignored index
            write_reg(sfnc_pkg::REG_COLOR_MODE, {$urandom_range(0, 1) ? 31'h7FFFFFFF : 31'h0,
                                                 1'(ph)});
            write_reg(sfnc_pkg::REG_COLORS_PRESENT, {31'($urandom), 1'(ph >> 1)});
            write_reg(8'($urandom_range(2, 255)), $urandom);
            quiet = (ph == PHASES - 1);
            for (int t = 0; t < TRIS_PHASE; t++) random_tri();
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: stl_facet_normal_and_color.f
rtl/sfnc_pkg.sv
rtl/sfnc_fifo.sv
rtl/sfnc_front.sv
rtl/sfnc_back.sv
rtl/stl_facet_normal_and_color.sv
dv/facet_watch.sv
dv/tb.sv
